// ===== hdl/irh_pkg.sv =====
package irh_pkg;

  // request kinds on the action input
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_READ = 1'b1;

  // result kinds
  localparam logic KIND_SET  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // set report status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_CAPACITY = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;

  // relation codes
  localparam int         NREL         = 7;
  localparam logic [2:0] REL_BEFORE   = 3'd0;
  localparam logic [2:0] REL_MEETS    = 3'd1;
  localparam logic [2:0] REL_OVERLAPS = 3'd2;
  localparam logic [2:0] REL_DURING   = 3'd3;
  localparam logic [2:0] REL_FINISHES = 3'd4;
  localparam logic [2:0] REL_STARTS   = 3'd5;
  localparam logic [2:0] REL_OTHER    = 3'd6;
  localparam logic [2:0] REL_INVALID  = 3'd7;

  // register map
  localparam logic [1:0] REG_NF   = 2'd0;
  localparam logic [4:0] NF_RESET = 5'd16;

  localparam logic [14:0] TOTAL_MAX = 15'h7fff;

  // sorting chain cell operations
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_POP    = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_op_t;

  // histogram store operations
  typedef enum logic [1:0] {
    CNT_NONE = 2'd0,
    CNT_READ = 2'd1,
    CNT_INCR = 2'd2
  } cnt_op_t;

  // histogram store status towards the controller
  typedef struct packed {
    logic clr_busy;
  } cnt_stat_t;

endpackage

// ===== hdl/irh_cell.sv =====
module irh_cell import irh_pkg::*; #(
  parameter int TB = 16,
  parameter int DW = 36
) (
  input  logic          clk,
  input  logic          rst,
  input  cell_op_t      op,
  input  logic [DW-1:0] new_data,
  input  logic [DW-1:0] head_data,
  input  logic [DW-1:0] prev_data,
  input  logic          prev_vld,
  input  logic          prev_aft,
  input  logic [DW-1:0] next_data,
  input  logic          next_vld,
  output logic [DW-1:0] data,
  output logic          vld,
  output logic          aft
);

  logic [DW-1:0] data_next;
  logic          vld_next;
  logic          take_ins;

  // held event sorts after the new one (start, then end; ties stay put)
  always_comb begin
    aft = vld && ((data[2*TB-1:TB] > new_data[2*TB-1:TB]) ||
                  ((data[2*TB-1:TB] == new_data[2*TB-1:TB]) &&
                   (data[TB-1:0] > new_data[TB-1:0])));
  end

  assign take_ins = (!vld && prev_vld) || aft;

  always_comb begin
    data_next = data;
    vld_next  = vld;
    case (op)
      CELL_INSERT: begin
        if (take_ins) begin
          data_next = prev_aft ? prev_data : new_data;
          vld_next  = 1'b1;
        end
      end
      CELL_POP: begin
        data_next = next_data;
        vld_next  = next_vld;
      end
      CELL_ROTATE: begin
        // last occupied cell takes the head
        if (vld) begin
          data_next = next_vld ? next_data : head_data;
        end
      end
      default: begin
        data_next = data;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= vld_next;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

// ===== hdl/irh_counts.sv =====
module irh_counts import irh_pkg::*; #(
  parameter int AW    = 11,
  parameter int DEPTH = 1792,
  parameter int CB    = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          clr_go,
  input  cnt_op_t       op,
  input  logic [AW-1:0] addr,
  output logic [CB-1:0] rd_data,
  output cnt_stat_t     stat
);

  logic [CB-1:0] mem [DEPTH];
  logic          clearing;
  logic [AW-1:0] clr_addr;
  logic          p_inc;
  logic [AW-1:0] p_addr;
  logic          lw_vld;
  logic [AW-1:0] lw_addr;
  logic [CB-1:0] lw_data;
  logic [CB-1:0] base;
  logic [CB-1:0] inc_val;

  // forward the write of the previous cycle, which the read missed
  assign base    = (lw_vld && (lw_addr == p_addr)) ? lw_data : rd_data;
  assign inc_val = (&base) ? base : base + 1'b1;
  assign stat.clr_busy = clearing;

  // store: clear sweep or saturating increment, one read a cycle
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (p_inc) begin
      mem[p_addr] <= inc_val;
    end
    if (op != CNT_NONE) begin
      rd_data <= mem[addr];
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
      p_inc    <= 1'b0;
      lw_vld   <= 1'b0;
    end else begin
      if (clr_go) begin
        clearing <= 1'b1;
        clr_addr <= '0;
      end else if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == AW'(DEPTH - 1)) begin
          clearing <= 1'b0;
        end
      end
      p_inc  <= (op == CNT_INCR);
      lw_vld <= p_inc;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    p_addr  <= addr;
    lw_addr <= p_addr;
    lw_data <= inc_val;
  end

  a_no_incr_in_clear: assert property (@(posedge clk) disable iff (rst)
    !(clearing && p_inc))
    else $error("increment during clear sweep");

  a_clr_starts: assert property (@(posedge clk) disable iff (rst)
    clr_go |=> clearing)
    else $error("clear request not taken");

endmodule

// ===== hdl/interval_relation_histogram.sv =====
// Interval relation histogram.
// Requests enter on start while busy is low. action selects a load of one
// event (event_feature, event_start, event_end, last_event) or a read of
// one count (read_first, read_second, read_relation).
// A read answers in the cycle after the request (done high, kind = 1).
// A load passes through the insert state and returns to idle; the first
// load after a finished set first clears the count store, one entry a cycle
// (MAX_FEATURES^2 * 7 entries, 1792 at the defaults). Events sit sorted in a
// chain of cells. A load with last_event set then pops each event off the
// chain head and rotates the remaining events past it, then passes through
// the drain and report states; done then pulses with kind = 0, pairs_total
// and status.
// Results are shown for exactly one cycle; the receiver cannot stall.
// Configuration: the feature count register over an APB-style port at
// address 0.
// After reset the count store is cleared by the same sweep, busy high.
module interval_relation_histogram import irh_pkg::*; #(
  parameter int MAX_EVENTS   = 256,
  parameter int MAX_FEATURES = 16,
  parameter int TIME_BITS    = 16,
  parameter int COUNT_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic        action,
  input  logic [3:0]  event_feature,
  input  logic [15:0] event_start,
  input  logic [15:0] event_end,
  input  logic        last_event,
  input  logic [3:0]  read_first,
  input  logic [3:0]  read_second,
  input  logic [2:0]  read_relation,
  output logic        done,
  output logic        kind,
  output logic [15:0] pair_count,
  output logic [14:0] pairs_total,
  output logic [1:0]  status
);

  localparam int FB    = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int TB    = TIME_BITS;
  localparam int DW    = FB + 2 * TB;
  localparam int ETW   = $clog2(MAX_EVENTS + 1);
  localparam int DEPTH = MAX_FEATURES * MAX_FEATURES * NREL;
  localparam int AW    = $clog2(DEPTH);
  localparam int CB    = COUNT_BITS;

  typedef enum logic [7:0] {
    S_INIT   = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_CLEAR  = 8'b0000_0100,
    S_INSERT = 8'b0000_1000,
    S_POP    = 8'b0001_0000,
    S_WALK   = 8'b0010_0000,
    S_DRAIN  = 8'b0100_0000,
    S_REPORT = 8'b1000_0000
  } state_t;

  state_t         state;
  logic [4:0]     nf_cfg;
  logic [ETW-1:0] event_total;
  logic [ETW-1:0] rem;
  logic [ETW-1:0] rot;
  logic           capacity_flag;
  logic           range_flag;
  logic           set_done;
  logic           walking;
  logic [14:0]    pairs_cnt;
  logic           rd_ok_r;

  logic [FB-1:0]  req_f;
  logic [3:0]     req_f_raw;
  logic [TB-1:0]  req_s;
  logic [TB-1:0]  req_e;
  logic           req_last;
  logic [DW-1:0]  anchor;

  logic [DW-1:0]  cdata [MAX_EVENTS];
  logic           cvld  [MAX_EVENTS];
  logic           caft  [MAX_EVENTS];
  cell_op_t       cop;
  logic [DW-1:0]  new_data;
  logic [DW-1:0]  head;

  cnt_op_t        c_op;
  logic [AW-1:0]  c_addr;
  logic [CB-1:0]  rd_data;
  cnt_stat_t      c_stat;
  logic           clr_go;

  logic           acc;
  logic [7:0]     nf_lim;
  logic           range_bad;
  logic           cap_full;
  logic           ins_ok;
  logic           rd_ok;
  logic [AW-1:0]  rd_addr;
  logic [TB-1:0]  a1, a2, b1, b2;
  logic [2:0]     rel;
  logic           pair;
  logic [AW-1:0]  pair_addr;

  // configuration port
  assign pready = 1'b1;
  assign prdata = 32'(nf_cfg);

  always_ff @(posedge clk) begin
    if (rst) begin
      nf_cfg <= NF_RESET;
    end else if (psel && penable && pwrite && (paddr == REG_NF)) begin
      nf_cfg <= pwdata[4:0];
    end
  end

  assign busy = (state != S_IDLE);
  assign acc  = start && !busy;

  // load checks
  always_comb begin
    if (nf_cfg == 5'd0) begin
      nf_lim = 8'd1;
    end else if (8'(nf_cfg) > 8'(MAX_FEATURES)) begin
      nf_lim = 8'(MAX_FEATURES);
    end else begin
      nf_lim = 8'(nf_cfg);
    end
  end
  assign range_bad = (8'(req_f_raw) >= nf_lim);
  assign cap_full  = (event_total == ETW'(MAX_EVENTS));
  assign ins_ok    = !range_bad && !cap_full;
  assign new_data  = {req_f, req_s, req_e};

  // count read address
  assign rd_ok = (8'(read_first) < 8'(MAX_FEATURES)) &&
                 (8'(read_second) < 8'(MAX_FEATURES)) &&
                 (read_relation != REL_INVALID);
  assign rd_addr = AW'((AW'(read_first) * AW'(MAX_FEATURES) + AW'(read_second)) *
                       AW'(NREL)) + AW'(read_relation);

  // relation of anchor (earlier) and chain head (later)
  assign head = cdata[0];
  assign a1 = anchor[2*TB-1:TB];
  assign a2 = anchor[TB-1:0];
  assign b1 = head[2*TB-1:TB];
  assign b2 = head[TB-1:0];

  always_comb begin
    if (a2 < b1) begin
      rel = REL_BEFORE;
    end else if (a2 == b1) begin
      rel = REL_MEETS;
    end else if ((a1 < b1) && (a2 < b2) && (b1 < a2)) begin
      rel = REL_OVERLAPS;
    end else if ((a1 < b1) && (b2 < a2)) begin
      rel = REL_DURING;
    end else if ((b1 < a1) && (a2 == b2)) begin
      rel = REL_FINISHES;
    end else if ((a1 == b1) && (a2 < b2)) begin
      rel = REL_STARTS;
    end else begin
      rel = REL_OTHER;
    end
  end

  assign pair = (state == S_WALK) && walking && (head[DW-1:2*TB] != anchor[DW-1:2*TB]);
  assign pair_addr = AW'((AW'(anchor[DW-1:2*TB]) * AW'(MAX_FEATURES) +
                          AW'(head[DW-1:2*TB])) * AW'(NREL)) + AW'(rel);

  // count store request
  always_comb begin
    c_op   = CNT_NONE;
    c_addr = pair_addr;
    if (acc && (action == ACT_READ)) begin
      c_op   = CNT_READ;
      c_addr = rd_addr;
    end else if (pair) begin
      c_op = CNT_INCR;
    end
  end

  assign clr_go = acc && (action == ACT_LOAD) && set_done;

  // chain operation
  always_comb begin
    case (state)
      S_INSERT: cop = ins_ok ? CELL_INSERT : CELL_HOLD;
      S_POP:    cop = CELL_POP;
      S_WALK:   cop = CELL_ROTATE;
      default:  cop = CELL_HOLD;
    endcase
  end

  // row of sorting cells
  for (genvar g = 0; g < MAX_EVENTS; g++) begin : g_cell
    logic [DW-1:0] pd;
    logic          pv;
    logic          pa;
    logic [DW-1:0] nd;
    logic          nv;
    if (g == 0) begin : g_first
      assign pd = '0;
      assign pv = 1'b1;
      assign pa = 1'b0;
    end else begin : g_mid
      assign pd = cdata[g-1];
      assign pv = cvld[g-1];
      assign pa = caft[g-1];
    end
    if (g == MAX_EVENTS - 1) begin : g_last
      assign nd = '0;
      assign nv = 1'b0;
    end else begin : g_body
      assign nd = cdata[g+1];
      assign nv = cvld[g+1];
    end
    irh_cell #(.TB(TB), .DW(DW)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .op        (cop),
      .new_data  (new_data),
      .head_data (head),
      .prev_data (pd),
      .prev_vld  (pv),
      .prev_aft  (pa),
      .next_data (nd),
      .next_vld  (nv),
      .data      (cdata[g]),
      .vld       (cvld[g]),
      .aft       (caft[g])
    );
  end

  irh_counts #(.AW(AW), .DEPTH(DEPTH), .CB(CB)) u_counts (
    .clk     (clk),
    .rst     (rst),
    .clr_go  (clr_go),
    .op      (c_op),
    .addr    (c_addr),
    .rd_data (rd_data),
    .stat    (c_stat)
  );

  // request payload and anchor
  always_ff @(posedge clk) begin
    if (acc && (action == ACT_LOAD)) begin
      req_f     <= FB'(event_feature);
      req_f_raw <= event_feature;
      req_s     <= TB'(event_start);
      req_e     <= TB'(event_end);
      req_last  <= last_event;
    end
    if (state == S_POP) begin
      anchor <= head;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_INIT;
      event_total   <= '0;
      rem           <= '0;
      rot           <= '0;
      capacity_flag <= 1'b0;
      range_flag    <= 1'b0;
      set_done      <= 1'b0;
      walking       <= 1'b0;
      pairs_cnt     <= '0;
      done          <= 1'b0;
      kind          <= KIND_SET;
      rd_ok_r       <= 1'b0;
      pairs_total   <= '0;
      status        <= ST_OK;
    end else begin
      done <= 1'b0;
      case (state)
        S_INIT: begin
          if (!c_stat.clr_busy) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (acc) begin
            if (action == ACT_READ) begin
              done        <= 1'b1;
              kind        <= KIND_READ;
              rd_ok_r     <= rd_ok;
              pairs_total <= '0;
              status      <= ST_OK;
            end else if (set_done) begin
              set_done <= 1'b0;
              state    <= S_CLEAR;
            end else begin
              state <= S_INSERT;
            end
          end
        end
        S_CLEAR: begin
          if (!c_stat.clr_busy) begin
            state <= S_INSERT;
          end
        end
        S_INSERT: begin
          if (range_bad) begin
            range_flag <= 1'b1;
          end else if (cap_full) begin
            capacity_flag <= 1'b1;
          end else begin
            event_total <= event_total + 1'b1;
          end
          if (req_last) begin
            rem       <= ins_ok ? event_total + 1'b1 : event_total;
            pairs_cnt <= '0;
            state     <= S_POP;
          end else begin
            state <= S_IDLE;
          end
        end
        S_POP: begin
          if (rem <= ETW'(1)) begin
            rem   <= '0;
            state <= S_DRAIN;
          end else begin
            rem     <= rem - 1'b1;
            rot     <= rem - 1'b1;
            walking <= 1'b1;
            state   <= S_WALK;
          end
        end
        S_WALK: begin
          if (head[DW-1:2*TB] == anchor[DW-1:2*TB]) begin
            walking <= 1'b0;
          end
          if (pair && (pairs_cnt != TOTAL_MAX)) begin
            pairs_cnt <= pairs_cnt + 1'b1;
          end
          rot <= rot - 1'b1;
          if (rot == ETW'(1)) begin
            state <= S_POP;
          end
        end
        S_DRAIN: begin
          state <= S_REPORT;
        end
        S_REPORT: begin
          done          <= 1'b1;
          kind          <= KIND_SET;
          rd_ok_r       <= 1'b0;
          pairs_total   <= pairs_cnt;
          status        <= capacity_flag ? ST_CAPACITY : (range_flag ? ST_RANGE : ST_OK);
          event_total   <= '0;
          capacity_flag <= 1'b0;
          range_flag    <= 1'b0;
          set_done      <= 1'b1;
          state         <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign pair_count = ((kind == KIND_READ) && rd_ok_r) ? 16'(rd_data) : 16'd0;

  a_report_empty: assert property (@(posedge clk) disable iff (rst)
    (done && (kind == KIND_SET)) |-> (event_total == '0) && !cvld[0])
    else $error("set report with events left in the chain");

  a_idle_no_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !c_stat.clr_busy)
    else $error("idle while count store is being cleared");

endmodule
